@@ src/ksc_pkg.sv @@
// Shared types, constants, timer advance and setpoint step functions for the keypad setpoint controller.
`default_nettype none
package ksc_pkg;

  localparam int unsigned TMR_W  = 12;
  localparam int unsigned TICK_W = 8;
  localparam int unsigned TEMP_W = 16;
  localparam int unsigned SPD_W  = 16;
  localparam int unsigned DUR_W  = 20;
  localparam int unsigned CFG_W  = 20;
  localparam int unsigned KEY_N  = 4;

  localparam int unsigned IN_TDATA_W  = 8;
  localparam int unsigned OUT_TDATA_W = 64;

  // key slots
  localparam int unsigned KEY_MENU  = 0;
  localparam int unsigned KEY_PLUS  = 1;
  localparam int unsigned KEY_MINUS = 2;
  localparam int unsigned KEY_START = 3;

  // latch slots
  localparam int unsigned LAT_MENU  = 0;
  localparam int unsigned LAT_START = 1;

  // config register indexes
  localparam logic [1:0] CFG_TICK     = 2'd0;
  localparam logic [1:0] CFG_TEMP_LIM = 2'd1;
  localparam logic [1:0] CFG_SPD_LIM  = 2'd2;
  localparam logic [1:0] CFG_DUR_LIM  = 2'd3;

  // timing thresholds in ms
  localparam logic [TMR_W-1:0] TMR_MAX     = 12'd4095;
  localparam logic [TMR_W-1:0] T_SHORT_MIN = 12'd100;
  localparam logic [TMR_W-1:0] T_SHORT_MAX = 12'd1500;
  localparam logic [TMR_W-1:0] T_PM_SHORT  = 12'd1400;
  localparam logic [TMR_W-1:0] T_REP_LO    = 12'd1900;
  localparam logic [TMR_W-1:0] T_REP_HI    = 12'd2100;
  localparam logic [TMR_W-1:0] T_LONG_MAX  = 12'd3000;
  localparam logic [TMR_W-1:0] HOLDOFF_SET = 12'd2000;

  // step sizes
  localparam logic [SPD_W-1:0] STEP_SMALL   = 16'd10;
  localparam logic [SPD_W-1:0] STEP_BIG     = 16'd100;
  localparam logic [DUR_W-1:0] STEP_T_SMALL = 20'd60;
  localparam logic [DUR_W-1:0] STEP_T_BIG   = 20'd600;
  localparam logic [SPD_W:0]   SPD_FLOOR    = 17'd50;

  // blink commands
  localparam logic [1:0] BLINK_NONE    = 2'd0;
  localparam logic [1:0] BLINK_RESTART = 2'd1;
  localparam logic [1:0] BLINK_CLEAR   = 2'd2;

  // reset values of config registers
  localparam logic [TICK_W-1:0] TICK_RST     = 8'd10;
  localparam logic [TEMP_W-1:0] TEMP_LIM_RST = 16'd3000;
  localparam logic [SPD_W-1:0]  SPD_LIM_RST  = 16'd1500;
  localparam logic [DUR_W-1:0]  DUR_LIM_RST  = 20'd86340;

  typedef enum logic [1:0] {
    MODE_NONE,
    MODE_TEMP,
    MODE_SPEED,
    MODE_TIME
  } mode_t;

  typedef struct packed {
    logic [TEMP_W-1:0] temp;
    logic [SPD_W-1:0]  speed;
    logic [DUR_W-1:0]  dur;
  } setp_t;

  // saturating timer advance
  function automatic logic [TMR_W-1:0] sat_time(logic [TMR_W-1:0] t,
                                                logic [TICK_W-1:0] tick);
    logic [TMR_W:0] s;
    s = {1'b0, t} + {5'd0, tick};
    return (s > {1'b0, TMR_MAX}) ? TMR_MAX : s[TMR_W-1:0];
  endfunction

  // one setpoint step in the given mode; mode none leaves values untouched
  function automatic setp_t edit_step(mode_t mode, logic up, logic big,
                                      setp_t v, setp_t lim);
    logic [SPD_W:0]   s16;
    logic [DUR_W:0]   s20;
    logic [SPD_W-1:0] d16;
    logic [DUR_W-1:0] d20;
    setp_t            r;
    r   = v;
    d16 = big ? STEP_BIG : STEP_SMALL;
    d20 = big ? STEP_T_BIG : STEP_T_SMALL;
    s16 = '0;
    s20 = '0;
    case (mode)
      MODE_TEMP: begin
        if (up) begin
          s16    = {1'b0, v.temp} + {1'b0, d16};
          r.temp = (s16 > {1'b0, lim.temp}) ? lim.temp : s16[TEMP_W-1:0];
        end else begin
          r.temp = (v.temp > d16) ? v.temp - d16 : '0;
        end
      end
      MODE_SPEED: begin
        if (up) begin
          s16 = {1'b0, v.speed} + {1'b0, d16};
          // first short step from zero jumps to the minimum speed
          if (!big && s16 == {1'b0, STEP_SMALL}) s16 = SPD_FLOOR;
          r.speed = (s16 > {1'b0, lim.speed}) ? lim.speed : s16[SPD_W-1:0];
        end else begin
          r.speed = ({1'b0, v.speed} < ({1'b0, d16} + SPD_FLOOR)) ? '0 : v.speed - d16;
        end
      end
      MODE_TIME: begin
        if (up) begin
          s20   = {1'b0, v.dur} + {1'b0, d20};
          r.dur = (s20 > {1'b0, lim.dur}) ? lim.dur : s20[DUR_W-1:0];
        end else begin
          r.dur = (v.dur > d20) ? v.dur - d20 : '0;
        end
      end
      default: r = v;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

@@ src/keypad_setpoint_controller.sv @@
// Top level of the keypad setpoint controller: key timing, setpoint editing and commands.
//
// Usage:
//   in_*  : one word per timer tick carrying the four key levels and the
//           external running flag. cfg_*: write port for tick period and
//           the three setpoint limits; write only while no word is in flight.
//   out_* : one word per tick with edit mode, setpoints, beep requests,
//           blink command, hold-off status and start/stop pulses.
// Result: the result word is registered and appears in the cycle after its tick word is taken.
// Throughput: one word per cycle. in_tready is high whenever the output
//   register is empty or is being drained in the same cycle, so ticks
//   stream back to back; the whole tick update is one registered pass.
// Stall: while out_tvalid is high and out_tready low the result holds and
//   in_tready drops, so no tick is taken and no state advances.
// Reset (rst_n low, synchronous): timers, flags, latches, mode, setpoints
//   and hold-off clear to zero; limits return to 3000 / 1500 / 86340 and
//   the tick period to 10 ms; the output register empties.
`default_nettype none
module keypad_setpoint_controller (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  // tdata: [0] menu_pressed, [1] plus_pressed, [2] minus_pressed,
  //        [3] start_pressed, [4] running, [7:5] zero
  input  wire logic [ksc_pkg::IN_TDATA_W-1:0]    in_tdata,
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  // tdata: [1:0] edit_mode, [17:2] temp_setpoint, [33:18] speed_setpoint,
  //        [53:34] duration_setpoint, [54] short_beep, [55] double_beep,
  //        [57:56] blink_cmd, [58] hold_active, [59] start_cmd,
  //        [60] stop_cmd, [63:61] zero
  output logic [ksc_pkg::OUT_TDATA_W-1:0]        out_tdata,
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  input  wire logic                              cfg_we,
  input  wire logic [1:0]                        cfg_addr,
  input  wire logic [ksc_pkg::CFG_W-1:0]         cfg_wdata
);
  import ksc_pkg::*;

  // config registers
  logic [TICK_W-1:0] tick_r;
  setp_t             lim_r;

  // tick state
  logic [TMR_W-1:0] tmr_r   [KEY_N];
  logic [TMR_W-1:0] tmr_nxt [KEY_N];
  logic [KEY_N-1:0] flag_r, flag_nxt;
  logic [1:0]       latch_r, latch_nxt;
  mode_t            mode_r, mode_nxt;
  setp_t            setp_r, setp_nxt;
  logic [TMR_W-1:0] hold_r, hold_nxt;

  // output register
  logic                   out_valid_r;
  logic [OUT_TDATA_W-1:0] out_data_r, out_data_nxt;

  logic km, kp, kn, ks, run;
  logic accept;
  logic sb, db, start_p, stop_p;
  logic [1:0] blink;
  logic plus_step, plus_big, minus_step, minus_big;
  setp_t setp_a;

  assign km  = in_tdata[KEY_MENU];
  assign kp  = in_tdata[KEY_PLUS];
  assign kn  = in_tdata[KEY_MINUS];
  assign ks  = in_tdata[KEY_START];
  assign run = in_tdata[4];

  assign in_tready  = !out_valid_r || out_tready;
  assign accept     = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  always_comb begin
    for (int k = 0; k < KEY_N; k++) tmr_nxt[k] = tmr_r[k];
    flag_nxt   = flag_r;
    latch_nxt  = latch_r;
    mode_nxt   = mode_r;
    setp_nxt   = setp_r;
    setp_a     = setp_r;
    sb         = 1'b0;
    db         = 1'b0;
    blink      = BLINK_NONE;
    start_p    = 1'b0;
    stop_p     = 1'b0;
    plus_step  = 1'b0;
    plus_big   = 1'b0;
    minus_step = 1'b0;
    minus_big  = 1'b0;

    // hold-off counts down before any key is looked at
    hold_nxt = (hold_r > {4'd0, tick_r}) ? hold_r - {4'd0, tick_r} : '0;

    // menu key
    if (km && !latch_r[LAT_MENU]) begin
      tmr_nxt[KEY_MENU]  = sat_time(tmr_r[KEY_MENU], tick_r);
      flag_nxt[KEY_MENU] = 1'b1;
    end
    if (flag_nxt[KEY_MENU]) begin
      if (!km) begin
        if (tmr_nxt[KEY_MENU] > T_SHORT_MIN && tmr_nxt[KEY_MENU] < T_SHORT_MAX) begin
          if (run) begin
            db = 1'b1;
          end else begin
            mode_nxt = mode_t'(mode_r + 2'd1);
            sb       = 1'b1;
            blink    = BLINK_RESTART;
          end
        end
        flag_nxt[KEY_MENU]  = 1'b0;
        latch_nxt[LAT_MENU] = 1'b0;
        tmr_nxt[KEY_MENU]   = '0;
      end
      if (tmr_nxt[KEY_MENU] > T_SHORT_MAX && tmr_nxt[KEY_MENU] < T_LONG_MAX &&
          !latch_nxt[LAT_MENU]) begin
        db                  = 1'b1;
        latch_nxt[LAT_MENU] = 1'b1;
      end
    end

    // plus key
    if (kp) begin
      tmr_nxt[KEY_PLUS] = sat_time(tmr_r[KEY_PLUS], tick_r);
      if (tmr_nxt[KEY_PLUS] > T_REP_LO && tmr_nxt[KEY_PLUS] < T_REP_HI) begin
        plus_step          = 1'b1;
        plus_big           = 1'b1;
        flag_nxt[KEY_PLUS] = 1'b0;
        tmr_nxt[KEY_PLUS]  = T_PM_SHORT;
      end else begin
        flag_nxt[KEY_PLUS] = 1'b1;
      end
    end else if (flag_r[KEY_PLUS]) begin
      plus_step          = tmr_r[KEY_PLUS] < T_PM_SHORT;
      flag_nxt[KEY_PLUS] = 1'b0;
      tmr_nxt[KEY_PLUS]  = '0;
    end
    if (plus_step) begin
      if (mode_nxt == MODE_NONE) begin
        db = 1'b1;
      end else begin
        setp_a   = edit_step(mode_nxt, 1'b1, plus_big, setp_r, lim_r);
        hold_nxt = HOLDOFF_SET;
        blink    = BLINK_RESTART;
      end
    end
    setp_nxt = setp_a;

    // minus key, working on the values left by plus
    if (kn) begin
      tmr_nxt[KEY_MINUS] = sat_time(tmr_r[KEY_MINUS], tick_r);
      if (tmr_nxt[KEY_MINUS] > T_REP_LO && tmr_nxt[KEY_MINUS] < T_REP_HI) begin
        minus_step          = 1'b1;
        minus_big           = 1'b1;
        flag_nxt[KEY_MINUS] = 1'b0;
        tmr_nxt[KEY_MINUS]  = T_PM_SHORT;
      end else begin
        flag_nxt[KEY_MINUS] = 1'b1;
      end
    end else if (flag_r[KEY_MINUS]) begin
      minus_step          = tmr_r[KEY_MINUS] < T_PM_SHORT;
      flag_nxt[KEY_MINUS] = 1'b0;
      tmr_nxt[KEY_MINUS]  = '0;
    end
    if (minus_step) begin
      if (mode_nxt == MODE_NONE) begin
        db = 1'b1;
      end else begin
        setp_nxt = edit_step(mode_nxt, 1'b0, minus_big, setp_a, lim_r);
        hold_nxt = HOLDOFF_SET;
        blink    = BLINK_RESTART;
      end
    end

    // start key
    if (ks && !latch_r[LAT_START]) begin
      tmr_nxt[KEY_START]  = sat_time(tmr_r[KEY_START], tick_r);
      flag_nxt[KEY_START] = 1'b1;
    end
    if (flag_nxt[KEY_START]) begin
      if (!ks) begin
        if (tmr_nxt[KEY_START] > T_SHORT_MIN && tmr_nxt[KEY_START] < T_SHORT_MAX) begin
          if (!run && (setp_nxt.speed != '0 || setp_nxt.temp != '0)) begin
            start_p = 1'b1;
          end else begin
            stop_p = 1'b1;
          end
          sb       = 1'b1;
          blink    = BLINK_CLEAR;
          mode_nxt = MODE_NONE;
        end
        flag_nxt[KEY_START]  = 1'b0;
        latch_nxt[LAT_START] = 1'b0;
        tmr_nxt[KEY_START]   = '0;
      end
      if (tmr_nxt[KEY_START] > T_SHORT_MAX && tmr_nxt[KEY_START] < T_LONG_MAX &&
          !latch_nxt[LAT_START]) begin
        db                   = 1'b1;
        latch_nxt[LAT_START] = 1'b1;
      end
    end

    out_data_nxt = {3'd0, stop_p, start_p, (hold_nxt != '0), blink, db, sb,
                    setp_nxt.dur, setp_nxt.speed, setp_nxt.temp, mode_nxt};
  end

  // config writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_r <= TICK_RST;
      lim_r  <= '{temp: TEMP_LIM_RST, speed: SPD_LIM_RST, dur: DUR_LIM_RST};
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_TICK:     tick_r    <= cfg_wdata[TICK_W-1:0];
        CFG_TEMP_LIM: lim_r.temp  <= cfg_wdata[TEMP_W-1:0];
        CFG_SPD_LIM:  lim_r.speed <= cfg_wdata[SPD_W-1:0];
        CFG_DUR_LIM:  lim_r.dur   <= cfg_wdata[DUR_W-1:0];
        default:      tick_r    <= tick_r;
      endcase
    end
  end

  // tick state, advanced once per taken word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < KEY_N; k++) tmr_r[k] <= '0;
      flag_r  <= '0;
      latch_r <= '0;
      mode_r  <= MODE_NONE;
      setp_r  <= '0;
      hold_r  <= '0;
    end else if (accept) begin
      for (int k = 0; k < KEY_N; k++) tmr_r[k] <= tmr_nxt[k];
      flag_r  <= flag_nxt;
      latch_r <= latch_nxt;
      mode_r  <= mode_nxt;
      setp_r  <= setp_nxt;
      hold_r  <= hold_nxt;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data_r <= out_data_nxt;
    end
  end

  // a long-press latch only exists while its key is tracked
  a_menu_latch: assert property (@(posedge clk) disable iff (!rst_n)
    latch_r[LAT_MENU] |-> flag_r[KEY_MENU])
    else $error("menu latch set without press flag");

  a_start_latch: assert property (@(posedge clk) disable iff (!rst_n)
    latch_r[LAT_START] |-> flag_r[KEY_START])
    else $error("start latch set without press flag");

  // start and stop are exclusive and both drop the edit mode
  a_cmd_mode: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_data_r[59] || out_data_r[60])) |->
      (!(out_data_r[59] && out_data_r[60]) && out_data_r[1:0] == MODE_NONE))
    else $error("start/stop command with bad mode or both set");

  // blink code is never the unused value
  a_blink: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_data_r[57:56] == BLINK_NONE ||
                     out_data_r[57:56] == BLINK_RESTART ||
                     out_data_r[57:56] == BLINK_CLEAR))
    else $error("invalid blink command");

  // hold-off status follows the counter of the word just taken
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (out_data_r[58] == (hold_r != '0)))
    else $error("hold_active mismatch");

endmodule
`default_nettype wire
